### src/npcs_pkg.sv
// Package with shared constants and types for the nearest palette color search.
`default_nettype none
package npcs_pkg;

  localparam int PALETTE_SIZE = 256;
  localparam int IDX_W        = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int COMP_W       = 8;
  localparam int ENTRY_W      = 3 * COMP_W;
  localparam int SQ_W         = 2 * COMP_W;
  localparam int DIST_W       = SQ_W + 2;
  localparam int OUT_IDX_W    = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] best_idx;
  } scan_res_t;

endpackage
`default_nettype wire

### src/npcs_palette_ram.sv
// Generic single-port-write, single-port-read synchronous RAM for the palette.
`default_nettype none
module npcs_palette_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 24,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### src/npcs_dist_unit.sv
// Distance pipeline: squared RGB distance per entry and running minimum.
`default_nettype none
module npcs_dist_unit
  import npcs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire scan_tag_t          ent_tag,
  input  wire logic [ENTRY_W-1:0] ent_data,
  input  wire logic [COMP_W-1:0]  q_red,
  input  wire logic [COMP_W-1:0]  q_green,
  input  wire logic [COMP_W-1:0]  q_blue,
  output scan_res_t               res
);

  scan_tag_t         tag1_r, tag2_r;
  logic [SQ_W-1:0]   sq_r_r, sq_g_r, sq_b_r;
  logic [DIST_W-1:0] sum_r;
  logic [DIST_W-1:0] best_dist_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic              done_r;

  logic [COMP_W-1:0] e_red, e_green, e_blue;
  logic [COMP_W-1:0] d_red, d_green, d_blue;

  assign e_red   = ent_data[COMP_W-1:0];
  assign e_green = ent_data[2*COMP_W-1:COMP_W];
  assign e_blue  = ent_data[3*COMP_W-1:2*COMP_W];

  assign d_red   = (q_red   >= e_red)   ? (q_red   - e_red)   : (e_red   - q_red);
  assign d_green = (q_green >= e_green) ? (q_green - e_green) : (e_green - q_green);
  assign d_blue  = (q_blue  >= e_blue)  ? (q_blue  - e_blue)  : (e_blue  - q_blue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      done_r <= 1'b0;
    end else begin
      tag1_r <= ent_tag;
      tag2_r <= tag1_r;
      done_r <= tag2_r.valid && tag2_r.last;
    end
    sq_r_r <= SQ_W'(d_red)   * SQ_W'(d_red);
    sq_g_r <= SQ_W'(d_green) * SQ_W'(d_green);
    sq_b_r <= SQ_W'(d_blue)  * SQ_W'(d_blue);
    sum_r  <= DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);
    if (tag2_r.valid && (tag2_r.first || (sum_r < best_dist_r))) begin
      best_dist_r <= sum_r;
      best_idx_r  <= tag2_r.idx;
    end
  end

  assign res.done     = done_r;
  assign res.best_idx = best_idx_r;

endmodule
`default_nettype wire

### src/nearest_palette_color_search_top.sv
// Top level of the nearest palette color search: handshakes, scan control, result register.
//
//  Channel | Ports                 | Contents
//  --------+-----------------------+--------------------------------------------------
//  in_     | tvalid tready tdata   | tdata: entry_index, red, green, blue (32 bits)
//          | tuser                 | tuser: operation (0 write entry, 1 query)
//  out_    | tvalid tready tdata   | tdata: nearest_index (8 bits)
//
// A query scans the whole palette: the palette memory's single read port delivers one
// entry per cycle, followed by the square, sum, compare and result stages. Reset is
// synchronous and clears only control state; the palette holds no reset value. A
// waiting result does not block the next request; a finished query waits in its own
// stage until the output register is free.
`default_nettype none
module nearest_palette_color_search_top
  import npcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // entry_index, red, green, blue
  input  wire logic        in_tuser,   // operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // nearest_index
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  state_t               state_r;
  logic [IDX_W-1:0]     rd_addr_r;
  logic [COMP_W-1:0]    q_red_r, q_green_r, q_blue_r;
  scan_tag_t            tag_r;
  logic                 out_valid_r;
  logic [OUT_IDX_W-1:0] out_data_r;

  logic [COMP_W-1:0]  in_entry_index, in_red, in_green, in_blue;
  logic               in_fire;
  logic               wr_en;
  logic               rd_en;
  logic               last_addr;
  logic [ENTRY_W-1:0] rd_data;
  scan_res_t          res;
  logic               out_free;

  assign in_entry_index = in_tdata[7:0];
  assign in_red         = in_tdata[15:8];
  assign in_green       = in_tdata[23:16];
  assign in_blue        = in_tdata[31:24];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign wr_en     = in_fire && (in_tuser == OP_WRITE)
                     && ({24'd0, in_entry_index} < 32'(PALETTE_SIZE));
  assign rd_en     = (state_r == ST_SCAN);
  assign last_addr = (rd_addr_r == IDX_W'(PALETTE_SIZE - 1));
  assign out_free  = !out_valid_r || out_tready;

  npcs_palette_ram #(
    .DEPTH  (PALETTE_SIZE),
    .WIDTH  (ENTRY_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(in_entry_index)),
    .wr_data ({in_blue, in_green, in_red}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  npcs_dist_unit u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .ent_tag  (tag_r),
    .ent_data (rd_data),
    .q_red    (q_red_r),
    .q_green  (q_green_r),
    .q_blue   (q_blue_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_addr_r   <= '0;
      tag_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tag_r.valid <= rd_en;
      tag_r.first <= (rd_addr_r == '0);
      tag_r.last  <= last_addr;
      tag_r.idx   <= rd_addr_r;
      if (out_valid_r && out_tready && (state_r != ST_HOLD)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && (in_tuser == OP_QUERY)) begin
            rd_addr_r <= '0;
            state_r   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_addr_r <= rd_addr_r + IDX_W'(1);
          if (last_addr) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (res.done) begin
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= OUT_IDX_W'(res.best_idx);
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
    if (in_fire && (in_tuser == OP_QUERY)) begin
      q_red_r   <= in_red;
      q_green_r <= in_green;
      q_blue_r  <= in_blue;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
